/* design/tcw_pkg.sv */
// tcw_pkg: shared types and fixed constants for the text console writer.
// No dependencies.

package tcw_pkg;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int LIN_OUT_W  = 11;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [LIN_OUT_W-1:0] linear;
        logic                 rd_hit;
    } tcw_res_t;

endpackage

/* design/text_console_writer.sv */
// text_console_writer: top level of the text console engine.
// Depends on tcw_pkg, tcw_ctrl, tcw_addr_unit and tcw_screen_ram.
//
// Usage:
//   Request channel in_valid/in_ready carries operation, char_code,
//   cell_row, cell_col and fill_attr. Result channel out_valid/out_ready
//   returns the cursor, its linear position and, for a read, the cell.
//   cfg_wr_en/cfg_wr_data write the text attribute; write only while idle.
// Steps, per request, from acceptance to the result state ST_DONE:
//   return, newline without scroll, read, unused code: straight to ST_DONE
//   printable, backspace: a write step (backspace at home: none); tab: a write
//   step per cell written; clear: one cell written per cycle over the screen
//   scroll adds a read/write sweep that moves each row up one, a drain
//   step, then a blank fill of the bottom row.
// One request is in flight at a time; in_ready returns after the result
// moves into the output register, so a new request can be taken while
// the previous result waits. If the receiver stalls, the result holds and
// the sequencer waits in its final step.
// Reset homes the cursor and sets the attribute to 07h; the screen store
// holds nothing defined until it is written, as by a clear.

module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_code,
    input  logic [4:0]  cell_row,
    input  logic [6:0]  cell_col,
    input  logic [7:0]  fill_attr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  cursor_row_out,
    output logic [6:0]  cursor_col_out,
    output logic [10:0] cursor_linear,
    output logic [7:0]  read_char,
    output logic [7:0]  read_attr,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    logic [tcw_pkg::ATTR_W-1:0]  text_attr_reg;
    logic [RW-1:0]               addr_row;
    logic [CW-1:0]               addr_col;
    logic [AW-1:0]               addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tcw_pkg::CELL_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [tcw_pkg::CELL_W-1:0]  rd_data;
    logic                        res_valid;
    logic                        res_ready;
    tcw_pkg::tcw_res_t           res;

    logic                        out_valid_reg;
    logic [4:0]                  row_out_reg;
    logic [6:0]                  col_out_reg;
    logic [10:0]                 lin_out_reg;
    logic [7:0]                  rd_char_reg;
    logic [7:0]                  rd_attr_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (cfg_wr_en)
        begin
            text_attr_reg <= cfg_wr_data;
        end
    end

    tcw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .char_code (char_code),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .fill_attr (fill_attr),
        .text_attr (text_attr_reg),
        .addr_row  (addr_row),
        .addr_col  (addr_col),
        .addr      (addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tcw_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .row  (addr_row),
        .col  (addr_col),
        .addr (addr)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            row_out_reg <= res.row;
            col_out_reg <= res.col;
            lin_out_reg <= res.linear;
            rd_char_reg <= res.rd_hit ? rd_data[tcw_pkg::CHAR_W-1:0] : '0;
            rd_attr_reg <= res.rd_hit ? rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;
    assign cursor_linear  = lin_out_reg;
    assign read_char      = rd_char_reg;
    assign read_attr      = rd_attr_reg;

endmodule

/* design/tcw_screen_ram.sv */
// tcw_screen_ram: character-cell screen store, one write and one read port,
// registered read data. Depends on tcw_pkg.

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/tcw_addr_unit.sv */
// tcw_addr_unit: shared row/column to linear cell address unit.
// No dependencies.

module tcw_addr_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [$clog2(ROWS)-1:0]          row,
    input  logic [$clog2(COLUMNS)-1:0]       col,
    output logic [$clog2(COLUMNS*ROWS)-1:0]  addr
);

    localparam int AW = $clog2(COLUMNS * ROWS);

    logic [31:0] prod;

    assign prod = 32'(row) * 32'(COLUMNS) + 32'(col);
    assign addr = prod[AW-1:0];

endmodule

/* design/tcw_ctrl.sv */
// tcw_ctrl: operation sequencer with cursor, clear, tab and scroll sweeps.
// Depends on tcw_pkg; drives tcw_screen_ram and tcw_addr_unit.

module tcw_ctrl #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tcw_pkg::OP_W-1:0]            operation,
    input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
    input  logic [4:0]                          cell_row,
    input  logic [6:0]                          cell_col,
    input  logic [tcw_pkg::ATTR_W-1:0]          fill_attr,
    input  logic [tcw_pkg::ATTR_W-1:0]          text_attr,
    output logic [$clog2(ROWS)-1:0]             addr_row,
    output logic [$clog2(COLUMNS)-1:0]          addr_col,
    input  logic [$clog2(COLUMNS*ROWS)-1:0]     addr,
    output logic                                wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]          wr_data,
    output logic                                rd_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]          rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output tcw_pkg::tcw_res_t                   res
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(TAB_STOP);

    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [PW-1:0] LAST_PHASE = PW'(TAB_STOP - 1);
    localparam logic [PW-1:0] WRAP_PHASE = PW'((COLUMNS - 1) % TAB_STOP);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_CELLS  = AW'(COLUMNS);
    localparam logic [AW-1:0] FILL_START = AW'((ROWS - 1) * COLUMNS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_WRITE  = 8'b0000_0010,
        ST_BLANK  = 8'b0000_0100,
        ST_CLEAR  = 8'b0000_1000,
        ST_SCROLL = 8'b0001_0000,
        ST_DRAIN  = 8'b0010_0000,
        ST_SFILL  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [PW-1:0]                 phase_reg, phase_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;
    logic [AW-1:0]                 pend_addr_reg, pend_addr_next;
    logic                          tab_reg, tab_next;
    logic                          hit_reg, hit_next;
    logic [tcw_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic [tcw_pkg::ATTR_W-1:0]    fill_reg, fill_next;
    logic [PW-1:0]                 phase_inc;
    logic                          read_in_range;
    logic [31:0]                   row_ext;
    logic [31:0]                   col_ext;
    logic [31:0]                   lin_ext;

    assign phase_inc     = (phase_reg == LAST_PHASE) ? '0 : phase_reg + PW'(1);
    assign read_in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

    assign in_ready  = (state_reg == ST_IDLE);
    assign addr_row  = in_ready ? RW'(32'(cell_row)) : row_reg;
    assign addr_col  = in_ready ? CW'(32'(cell_col)) : col_reg;

    assign row_ext    = 32'(row_reg);
    assign col_ext    = 32'(col_reg);
    assign lin_ext    = 32'(addr);
    assign res_valid  = (state_reg == ST_DONE);
    assign res.row    = row_ext[tcw_pkg::ROW_OUT_W-1:0];
    assign res.col    = col_ext[tcw_pkg::COL_OUT_W-1:0];
    assign res.linear = lin_ext[tcw_pkg::LIN_OUT_W-1:0];
    assign res.rd_hit = hit_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        tab_next       = tab_reg;
        hit_next       = hit_reg;
        char_next      = char_reg;
        fill_next      = fill_reg;
        wr_en          = pend_reg;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                    case (operation)
                        tcw_pkg::OP_PUT:
                        begin
                            case (char_code)
                                tcw_pkg::CH_LF:
                                begin
                                    col_next   = '0;
                                    phase_next = '0;
                                    if (row_reg == LAST_ROW)
                                    begin
                                        cnt_next   = ROW_CELLS;
                                        state_next = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + RW'(1);
                                    end
                                end
                                tcw_pkg::CH_BS:
                                begin
                                    char_next = tcw_pkg::CH_BLANK;
                                    if (col_reg != '0)
                                    begin
                                        col_next   = col_reg - CW'(1);
                                        phase_next = (phase_reg == '0) ? LAST_PHASE
                                                                       : phase_reg - PW'(1);
                                        state_next = ST_BLANK;
                                    end
                                    else if (row_reg != '0)
                                    begin
                                        row_next   = row_reg - RW'(1);
                                        col_next   = LAST_COL;
                                        phase_next = WRAP_PHASE;
                                        state_next = ST_BLANK;
                                    end
                                end
                                tcw_pkg::CH_CR:
                                begin
                                    col_next   = '0;
                                    phase_next = '0;
                                end
                                tcw_pkg::CH_TAB:
                                begin
                                    char_next  = tcw_pkg::CH_BLANK;
                                    tab_next   = 1'b1;
                                    state_next = ST_WRITE;
                                end
                                default:
                                begin
                                    char_next  = char_code;
                                    tab_next   = 1'b0;
                                    state_next = ST_WRITE;
                                end
                            endcase
                        end
                        tcw_pkg::OP_READ:
                        begin
                            hit_next = read_in_range;
                            rd_en    = read_in_range;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            fill_next  = fill_attr;
                            cnt_next   = '0;
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = addr;
                wr_data = {text_attr, char_reg};
                if (col_reg == LAST_COL)
                begin
                    col_next   = '0;
                    phase_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        cnt_next   = ROW_CELLS;
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    phase_next = phase_inc;
                    if (!tab_reg || phase_inc == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BLANK:
            begin
                wr_en      = 1'b1;
                wr_addr    = addr;
                wr_data    = {text_attr, char_reg};
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = {fill_reg, tcw_pkg::CH_BLANK};
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                // read one row down, write it back one row up in the following cycle
                rd_en          = 1'b1;
                rd_addr        = cnt_reg;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg - ROW_CELLS;
                cnt_next       = cnt_reg + AW'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next   = FILL_START;
                state_next = ST_SFILL;
            end
            ST_SFILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = {text_attr, tcw_pkg::CH_BLANK};
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        pend_addr_reg <= pend_addr_next;
        tab_reg       <= tab_next;
        char_reg      <= char_next;
        fill_reg      <= fill_next;
    end

endmodule

/* design/tcw_checker.sv */
// tcw_checker: port-level assertions for text_console_writer, bound to the top.
// No package dependency.

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  cursor_row_out,
    input logic [6:0]  cursor_col_out,
    input logic [10:0] cursor_linear
);

    logic [31:0] lin_calc;

    assign lin_calc = 32'(cursor_row_out) * 32'(COLUMNS) + 32'(cursor_col_out);

    // one request in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_linear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_linear == lin_calc[10:0])
        else $error("cursor linear position mismatch");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_row_out) < ROWS) && (32'(cursor_col_out) < COLUMNS))
        else $error("cursor out of screen");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_linear))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_linear  (cursor_linear)
);
